// ===== src/gdf_pkg.sv =====
package gdf_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int COORD_W   = $clog2(MAX_DIM);
    localparam int DIM_W     = COORD_W + 1;
    localparam int COLOR_W   = 48;
    localparam int BYTE_W    = 8;
    localparam int NUM_CH    = 3;
    localparam int WH_W      = 2 * DIM_W;
    localparam int SUM_W     = COORD_W + DIM_W + 1;
    localparam int DIV_W     = WH_W + 1;
    localparam int REM_W     = DIV_W;
    localparam int M_W       = SUM_W + BYTE_W + 1;
    localparam int Q_W       = BYTE_W + 1;
    localparam int PDATA_W   = 64;
    localparam int PADDR_W   = 6;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_START  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_END    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_MODE   = 3'd4;

    localparam logic [1:0] MODE_VERT  = 2'd0;
    localparam logic [1:0] MODE_HORIZ = 2'd1;

    typedef struct packed {
        logic [COLOR_W-1:0] start_color;
        logic [COLOR_W-1:0] end_color;
        logic [DIM_W-1:0]   w_eff;
        logic [DIM_W-1:0]   h_eff;
        logic               vert;
        logic               horiz;
        logic [WH_W-1:0]    wh;
        logic [DIV_W-1:0]   divisor;
    } cfg_t;

    typedef struct packed {
        logic [NUM_CH-1:0][M_W-1:0]   m;
        logic [NUM_CH-1:0][REM_W-1:0] rem;
        logic [NUM_CH-1:0][Q_W-1:0]   q;
        logic [NUM_CH-1:0]            big;
        logic [NUM_CH-1:0]            neg;
        logic                         flr;
    } cell_t;

    function automatic logic [BYTE_W-1:0] chan_byte(input logic [COLOR_W-1:0] color,
                                                    input int idx);
        return color[(2 - idx) * 16 + 8 +: BYTE_W];
    endfunction

endpackage

// ===== src/gdf_if.sv =====
interface gdf_pix_if;
    logic                        valid;
    logic                        ready;
    logic [gdf_pkg::COORD_W-1:0] pixel_x;
    logic [gdf_pkg::COORD_W-1:0] pixel_y;
    modport source (output valid, pixel_x, pixel_y, input ready);
    modport sink (input valid, pixel_x, pixel_y, output ready);
endinterface

interface gdf_rgb_if;
    logic                       valid;
    logic                       ready;
    logic [gdf_pkg::BYTE_W-1:0] red_out;
    logic [gdf_pkg::BYTE_W-1:0] green_out;
    logic [gdf_pkg::BYTE_W-1:0] blue_out;
    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

// ===== src/gdf_cfg.sv =====
module gdf_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gdf_pkg::PADDR_W-1:0]  paddr,
    input  logic [gdf_pkg::PDATA_W-1:0]  pwdata,
    output logic [gdf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output gdf_pkg::cfg_t                cfg
);
    import gdf_pkg::*;

    logic [COLOR_W-1:0]   start_reg;
    logic [COLOR_W-1:0]   end_reg;
    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [1:0]           mode_reg;
    logic [WH_W-1:0]      wh_reg;
    logic [DIV_W-1:0]     div_reg;
    logic [DIV_W-1:0]     div_next;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic                 wr;
    logic [REG_IDX_W-1:0] idx;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[PADDR_W-1:PADDR_W-REG_IDX_W];
    assign pready = 1'b1;
    assign w_eff  = (width_reg == '0) ? DIM_W'(1) : width_reg;
    assign h_eff  = (height_reg == '0) ? DIM_W'(1) : height_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= '0;
            end_reg    <= '0;
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            mode_reg   <= MODE_VERT;
        end
        else if (wr)
        begin
            unique case (idx)
                REG_START:  start_reg  <= pwdata[COLOR_W-1:0];
                REG_END:    end_reg    <= pwdata[COLOR_W-1:0];
                REG_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_MODE:   mode_reg   <= pwdata[1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_VERT:  div_next = DIV_W'(h_eff);
            MODE_HORIZ: div_next = DIV_W'(w_eff);
            default:    div_next = {wh_reg, 1'b0};
        endcase
    end

    // product and divisor are registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wh_reg  <= WH_W'(1);
            div_reg <= DIV_W'(1);
        end
        else
        begin
            wh_reg  <= w_eff * h_eff;
            div_reg <= div_next;
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_START:  prdata = PDATA_W'(start_reg);
            REG_END:    prdata = PDATA_W'(end_reg);
            REG_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_MODE:   prdata = PDATA_W'(mode_reg);
            default:    prdata = '0;
        endcase
    end

    assign cfg.start_color = start_reg;
    assign cfg.end_color   = end_reg;
    assign cfg.w_eff       = w_eff;
    assign cfg.h_eff       = h_eff;
    assign cfg.vert        = (mode_reg == MODE_VERT);
    assign cfg.horiz       = (mode_reg == MODE_HORIZ);
    assign cfg.wh          = wh_reg;
    assign cfg.divisor     = div_reg;

endmodule

// ===== src/gdf_front.sv =====
module gdf_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [gdf_pkg::COORD_W-1:0] pixel_x,
    input  logic [gdf_pkg::COORD_W-1:0] pixel_y,
    input  gdf_pkg::cfg_t               cfg,
    output logic                        out_valid,
    output gdf_pkg::cell_t              out_data
);
    import gdf_pkg::*;

    logic [4:0]                    v_reg;
    logic [COORD_W-1:0]            x_reg;
    logic [COORD_W-1:0]            y_reg;
    logic [COORD_W-1:0]            x1_reg;
    logic [COORD_W-1:0]            y1_reg;
    logic [COORD_W+DIM_W-1:0]      xh_reg;
    logic [COORD_W+DIM_W-1:0]      yw_reg;
    logic [SUM_W-1:0]              s_reg;
    logic [SUM_W-1:0]              s_next;
    logic [NUM_CH-1:0][M_W-1:0]    p_reg;
    logic [NUM_CH-1:0]             dneg_reg;
    logic [NUM_CH-1:0][BYTE_W:0]   d;
    logic [NUM_CH-1:0][BYTE_W-1:0] d_abs;
    logic [NUM_CH-1:0][M_W-1:0]    m_reg;
    logic [NUM_CH-1:0][M_W-1:0]    m_next;
    logic [NUM_CH-1:0]             neg_reg;
    logic [NUM_CH-1:0]             neg_next;
    logic                          flr;
    logic [M_W-1:0]                bias;

    assign flr  = !(cfg.vert || cfg.horiz);
    assign bias = flr ? M_W'(cfg.wh) : '0;

    always_comb
    begin
        priority if (cfg.vert)
            s_next = SUM_W'(y1_reg);
        else if (cfg.horiz)
            s_next = SUM_W'(x1_reg);
        else
            s_next = SUM_W'(xh_reg) + SUM_W'(yw_reg);
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            d[c]     = {1'b0, chan_byte(cfg.end_color, c)}
                       - {1'b0, chan_byte(cfg.start_color, c)};
            d_abs[c] = d[c][BYTE_W] ? BYTE_W'(-d[c]) : d[c][BYTE_W-1:0];
            if (!dneg_reg[c])
            begin
                m_next[c]   = bias + p_reg[c];
                neg_next[c] = 1'b0;
            end
            else if (p_reg[c] <= bias)
            begin
                m_next[c]   = bias - p_reg[c];
                neg_next[c] = 1'b0;
            end
            else
            begin
                m_next[c]   = p_reg[c] - bias;
                neg_next[c] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[3:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= pixel_x;
            y_reg    <= pixel_y;
            x1_reg   <= x_reg;
            y1_reg   <= y_reg;
            xh_reg   <= x_reg * cfg.h_eff;
            yw_reg   <= y_reg * cfg.w_eff;
            s_reg    <= s_next;
            for (int c = 0; c < NUM_CH; c++)
            begin
                p_reg[c]    <= d_abs[c] * s_reg;
                dneg_reg[c] <= d[c][BYTE_W];
            end
            m_reg    <= m_next;
            neg_reg  <= neg_next;
        end
    end

    assign out_valid     = v_reg[4];
    assign out_data.m    = m_reg;
    assign out_data.rem  = '0;
    assign out_data.q    = '0;
    assign out_data.big  = '0;
    assign out_data.neg  = neg_reg;
    assign out_data.flr  = flr;

endmodule

// ===== src/gdf_div_cell.sv =====
module gdf_div_cell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic [gdf_pkg::DIV_W-1:0] divisor,
    input  logic                      in_valid,
    input  gdf_pkg::cell_t            in_data,
    output logic                      out_valid,
    output gdf_pkg::cell_t            out_data
);
    import gdf_pkg::*;

    logic [NUM_CH-1:0][REM_W:0] r2;
    logic [NUM_CH-1:0][REM_W:0] diff;
    logic [NUM_CH-1:0]          ge;
    cell_t                      data_next;
    logic                       valid_reg;
    cell_t                      data_reg;

    // one quotient bit per cell, restoring step
    always_comb
    begin
        data_next = in_data;
        for (int c = 0; c < NUM_CH; c++)
        begin
            r2[c]   = {in_data.rem[c], in_data.m[c][M_W-1]};
            diff[c] = r2[c] - {1'b0, divisor};
            ge[c]   = (r2[c] >= {1'b0, divisor});
            data_next.rem[c] = ge[c] ? diff[c][REM_W-1:0] : r2[c][REM_W-1:0];
            data_next.m[c]   = {in_data.m[c][M_W-2:0], 1'b0};
            data_next.q[c]   = {in_data.q[c][Q_W-2:0], ge[c]};
            data_next.big[c] = in_data.big[c] | in_data.q[c][Q_W-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== src/gradient_fill_pixel_unit.sv =====
// gradient fill pixel unit
// pix_in carries one pixel beat (pixel_x, pixel_y); rgb_out returns one beat
// (red_out, green_out, blue_out) per input beat, in order. both channels use
// valid/ready and a beat moves when both are high.
// the APB port holds start_color, end_color, width, height and
// gradient_mode at byte addresses 0, 8, 16, 24 and 32, 64-bit data; pready is
// always high. the user must write registers only while no pixel is in flight;
// the block itself does not enforce it. throughput is one pixel per clock while
// rgb_out does not stall. a result passes through five front stages (input
// register, coordinate products, position sum, color-delta product, signed bias),
// one cell per numerator bit of the 35-cell divider chain, and the output register.
// the divider chain produces one quotient bit per cell, so its length is set
// by the numerator width.
// when rgb_out stalls with a result held, the whole pipeline freezes and
// pix_in.ready drops; it returns as soon as the result is taken.
// reset clears all valid bits and loads the register reset values (colors 0,
// width and height 1, vertical mode); no pixel is in flight after reset.
module gradient_fill_pixel_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    gdf_pix_if.sink                      pix_in,
    gdf_rgb_if.source                    rgb_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gdf_pkg::PADDR_W-1:0]  paddr,
    input  logic [gdf_pkg::PDATA_W-1:0]  pwdata,
    output logic [gdf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import gdf_pkg::*;

    cfg_t                      cfg;
    logic                      en;
    logic [M_W:0]              chain_valid;
    cell_t                     chain_data [M_W+1];
    logic                      out_valid_reg;
    logic [NUM_CH-1:0][BYTE_W-1:0] rgb_reg;
    logic [NUM_CH-1:0][BYTE_W-1:0] rgb_next;
    logic [NUM_CH-1:0][Q_W:0]  q_fix;
    logic [NUM_CH-1:0][11:0]   val;
    cell_t                     last;

    assign en           = !out_valid_reg || rgb_out.ready;
    assign pix_in.ready = en;

    gdf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gdf_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pix_in.valid),
        .pixel_x   (pix_in.pixel_x),
        .pixel_y   (pix_in.pixel_y),
        .cfg       (cfg),
        .out_valid (chain_valid[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < M_W; i++)
    begin : g_cell
        gdf_div_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .divisor   (cfg.divisor),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    assign last = chain_data[M_W];

    // sign, floor correction and clamp to a byte
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            q_fix[c] = {1'b0, last.q[c]}
                       + (Q_W+1)'(last.neg[c] && last.flr && (last.rem[c] != '0));
            if (last.neg[c])
            begin
                val[c] = {4'b0, chan_byte(cfg.start_color, c)} - {2'b0, q_fix[c]};
                rgb_next[c] = (last.big[c] || val[c][11]) ? '0 : val[c][BYTE_W-1:0];
            end
            else
            begin
                val[c] = {4'b0, chan_byte(cfg.start_color, c)} + {2'b0, q_fix[c]};
                rgb_next[c] = (last.big[c] || (val[c] > 12'd255)) ? '1
                              : val[c][BYTE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= chain_valid[M_W];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            rgb_reg <= rgb_next;
    end

    assign rgb_out.valid     = out_valid_reg;
    assign rgb_out.red_out   = rgb_reg[0];
    assign rgb_out.green_out = rgb_reg[1];
    assign rgb_out.blue_out  = rgb_reg[2];

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(chain_valid) && $stable(rgb_reg))
        else $error("pipeline moved during output stall");

    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        en && chain_valid[M_W] |=> out_valid_reg)
        else $error("divider result dropped before output");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        pix_in.valid && pix_in.ready |=> u_front.v_reg[0])
        else $error("accepted pixel not in front stage");

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cfg.divisor != '0 && cfg.w_eff != '0 && cfg.h_eff != '0)
        else $error("zero divisor");

endmodule
